// ----- hw/rtl/source_text_lexer_core_defines.svh -----
// Assertion macros for the source text lexer core.
`ifndef SOURCE_TEXT_LEXER_CORE_DEFINES_SVH
`define SOURCE_TEXT_LEXER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define STL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define STL_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STL_ASSERT(lbl, prop, msg)
`define STL_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/stl_pkg.sv -----
// Shared types and constants of the source text lexer core.
`timescale 1ns / 1ps
package stl_pkg;

	localparam int BYTE_W      = 8;
	localparam int FIFO_DEPTH  = 4;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

	localparam logic [BYTE_W-1:0] STRING_DELIM_RST  = 8'd34;
	localparam logic [BYTE_W-1:0] COMMENT_DELIM_RST = 8'd36;
	localparam logic [BYTE_W-1:0] CHAR_DELIM_RST    = 8'd39;
	localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST   = 8'd92;

	typedef enum logic [1:0] {
		CFG_STRING  = 2'd0,
		CFG_COMMENT = 2'd1,
		CFG_CHAR    = 2'd2,
		CFG_ESCAPE  = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		CLS_BLANK   = 3'd0,
		CLS_WORD    = 3'd1,
		CLS_SYMBOL  = 3'd2,
		CLS_STRING  = 3'd3,
		CLS_COMMENT = 3'd4,
		CLS_CHAR    = 3'd5
	} cls_t;

	typedef struct packed {
		logic [BYTE_W-1:0] text;
		logic              last;
		logic              is_str;
		logic              is_cmt;
		logic              is_chr;
		logic              is_esc;
		logic              blank;
		logic              word;
	} item_t;

	typedef struct packed {
		logic             full;
		logic             empty;
		logic [CNT_W-1:0] count;
	} fifo_stat_t;

endpackage

// ----- hw/rtl/stl_front.sv -----
// Front end: configuration registers and byte classification.
`timescale 1ns / 1ps
module stl_front import stl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [BYTE_W-1:0] cfg_data,
	input  logic              in_valid,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              in_last,
	input  logic              q_full,
	output logic              in_ready,
	output logic              push,
	output item_t             push_item
);

	logic [BYTE_W-1:0] str_delim_q;
	logic [BYTE_W-1:0] cmt_delim_q;
	logic [BYTE_W-1:0] chr_delim_q;
	logic [BYTE_W-1:0] esc_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			str_delim_q <= STRING_DELIM_RST;
			cmt_delim_q <= COMMENT_DELIM_RST;
			chr_delim_q <= CHAR_DELIM_RST;
			esc_byte_q  <= ESCAPE_BYTE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_STRING:  str_delim_q <= cfg_data;
				CFG_COMMENT: cmt_delim_q <= cfg_data;
				CFG_CHAR:    chr_delim_q <= cfg_data;
				CFG_ESCAPE:  esc_byte_q  <= cfg_data;
				default:     esc_byte_q  <= esc_byte_q;
			endcase
		end
	end

	always_comb begin
		push_item.text   = in_byte;
		push_item.last   = in_last;
		push_item.is_str = (in_byte == str_delim_q);
		push_item.is_cmt = (in_byte == cmt_delim_q);
		push_item.is_chr = (in_byte == chr_delim_q);
		push_item.is_esc = (in_byte == esc_byte_q);
		push_item.blank  = (in_byte == 8'h20) || (in_byte == 8'h09) || (in_byte == 8'h0B) ||
		                   (in_byte == 8'h0C) || (in_byte == 8'h0D);
		push_item.word   = ((in_byte >= 8'h30) && (in_byte <= 8'h39)) ||
		                   ((in_byte >= 8'h41) && (in_byte <= 8'h5A)) ||
		                   ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ||
		                   (in_byte == 8'h5F);
	end

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

endmodule

// ----- hw/rtl/stl_fifo.sv -----
// Short queue of classified bytes between front and back end.
`timescale 1ns / 1ps
module stl_fifo import stl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  item_t      push_item,
	input  logic       pop,
	output item_t      pop_item,
	output fifo_stat_t stat
);

	item_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_item   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule

// ----- hw/rtl/stl_back.sv -----
// Back end: lexer mode machine and output register.
`timescale 1ns / 1ps
module stl_back import stl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  item_t             item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_start,
	output cls_t              out_class,
	output logic              out_drop,
	output logic              out_last,
	output logic              out_unterm
);

	cls_t mode_q;
	cls_t mode_d;
	logic esc_q;
	logic esc_d;
	logic lit;
	logic closes;
	cls_t cls_c;
	logic start_c;
	logic drop_c;
	logic unterm_c;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_start_q;
	cls_t              out_class_q;
	logic              out_drop_q;
	logic              out_last_q;
	logic              out_unterm_q;

	assign lit = (mode_q == CLS_STRING) || (mode_q == CLS_COMMENT) || (mode_q == CLS_CHAR);
	assign closes = ((mode_q == CLS_STRING) && item.is_str) ||
	                ((mode_q == CLS_COMMENT) && item.is_cmt) ||
	                ((mode_q == CLS_CHAR) && item.is_chr);

	assign pop = !q_empty && (!out_valid_q || out_ready);

	always_comb begin
		priority if (item.is_str) begin
			cls_c = CLS_STRING;
		end else if (item.is_cmt) begin
			cls_c = CLS_COMMENT;
		end else if (item.is_chr) begin
			cls_c = CLS_CHAR;
		end else if (item.blank) begin
			cls_c = CLS_BLANK;
		end else if (item.word) begin
			cls_c = CLS_WORD;
		end else begin
			cls_c = CLS_SYMBOL;
		end
	end

	always_comb begin
		mode_d = mode_q;
		esc_d  = esc_q;
		if (lit) begin
			if (esc_q) begin
				esc_d = 1'b0;
			end else if (item.is_esc) begin
				esc_d = 1'b1;
			end else if (closes) begin
				mode_d = CLS_SYMBOL;
			end
		end else begin
			esc_d  = 1'b0;
			mode_d = cls_c;
		end
		if (item.last) begin
			mode_d = CLS_SYMBOL;
			esc_d  = 1'b0;
		end
	end

	always_comb begin
		start_c  = 1'b0;
		drop_c   = 1'b0;
		unterm_c = 1'b0;
		if (lit) begin
			unterm_c = item.last && (esc_q || item.is_esc || !closes);
		end else begin
			unique case (cls_c)
				CLS_BLANK: begin
					drop_c  = (mode_q == CLS_BLANK);
					start_c = (mode_q != CLS_BLANK);
				end
				CLS_WORD:    start_c = (mode_q != CLS_WORD);
				CLS_SYMBOL:  start_c = 1'b1;
				CLS_STRING,
				CLS_COMMENT,
				CLS_CHAR: begin
					start_c  = 1'b1;
					unterm_c = item.last;
				end
				default:     start_c = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= CLS_SYMBOL;
			esc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q      <= mode_d;
				esc_q       <= esc_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q   <= item.text;
			out_start_q  <= start_c;
			out_class_q  <= lit ? mode_q : cls_c;
			out_drop_q   <= drop_c;
			out_last_q   <= item.last;
			out_unterm_q <= unterm_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign out_start  = out_start_q;
	assign out_class  = out_class_q;
	assign out_drop   = out_drop_q;
	assign out_last   = out_last_q;
	assign out_unterm = out_unterm_q;

endmodule

// ----- hw/rtl/source_text_lexer_core.sv -----
// Top level of the source text lexer core.
`timescale 1ns / 1ps
`include "source_text_lexer_core_defines.svh"
// The core takes one byte of source text per cycle and returns one tagged byte per
// cycle unless the queue is full or the output stalls: token start, token class, a
// drop flag for repeated blanks and an open-literal flag on the last byte. A byte is
// classified against the four delimiter registers on entry, written into a
// four-entry queue, and leaves through the mode machine's output register. A byte
// passes the queue and then the output register before it shows on the output. The
// mode machine sets the rate of one byte per cycle while the output is not stalled;
// the queue lets the input keep going for up to four bytes while the output stalls.
// Write the delimiter registers only while no byte is in flight.
module source_text_lexer_core import stl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [BYTE_W-1:0] cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] text_byte
	input  logic              s_tlast,   // end_of_text
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
	output logic [5:0]        m_tuser,   // [0] token_start, [3:1] token_class,
	                                     // [4] drop_blank, [5] unterminated
	output logic              m_tlast    // last_byte
);

	logic       push;
	item_t      push_item;
	logic       pop;
	item_t      pop_item;
	fifo_stat_t q_stat;
	logic       out_start;
	cls_t       out_class;
	logic       out_drop;
	logic       out_unterm;

	stl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.q_full    (q_stat.full),
		.in_ready  (s_tready),
		.push      (push),
		.push_item (push_item)
	);

	stl_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (q_stat)
	);

	stl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_stat.empty),
		.item       (pop_item),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_start  (out_start),
		.out_class  (out_class),
		.out_drop   (out_drop),
		.out_last   (m_tlast),
		.out_unterm (out_unterm)
	);

	assign m_tuser = {out_unterm, out_drop, out_class, out_start};

	`STL_ASSERT(a_fifo_bound, q_stat.count <= CNT_W'(FIFO_DEPTH), "queue count beyond depth")
	`STL_ASSERT(a_unterm_last, m_tvalid && m_tuser[5] |-> m_tlast, "open literal flag off last")
	`STL_ASSERT(a_drop_blank, m_tvalid && m_tuser[4] |-> (m_tuser[3:1] == CLS_BLANK) && !m_tuser[0], "drop flag on non-blank or token start")
	`STL_ASSERT_RST(a_reset_idle, !arst_n |=> !m_tvalid && q_stat.empty, "activity during reset")

endmodule
